FILE: rtl/core/rivf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rivf_pkg
// Shared types, register indexes and constants of the color fusion block.
// ----------------------------------------------------------------------------
package rivf_pkg;

	localparam int COLOR_FRAC_BITS_DEF = 8;

	localparam logic [23:0] NOISE_RESET = 24'd1678;
	localparam logic [9:0]  RATIO_RESET = 10'd307;

	localparam logic CFG_NOISE = 1'b0;
	localparam logic CFG_RATIO = 1'b1;

	localparam logic [1:0] ST_REJECT = 2'd0;
	localparam logic [1:0] ST_FIRST  = 2'd1;
	localparam logic [1:0] ST_FUSED  = 2'd2;

	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 50;

	typedef struct packed {
		logic       capture;
		logic       dt;
		logic       mul;
		logic       first;
		logic       grow;
		logic       p0;
		logic       p1;
		logic       p2;
		logic       p3;
		logic       sq_step;
		logic       dv_sig_start;
		logic       dv_col_start;
		logic       dv_step;
		logic       wr_ch;
		logic       finish;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic first;
		logic sq_done;
		logic dv_done;
	} sts_t;

endpackage

FILE: rtl/core/rivf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rivf_ctrl
// Sequencer that walks one observation through gate, noise and channel fusion.
// ----------------------------------------------------------------------------
module rivf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output rivf_pkg::cmd_t  cmd,
	input  rivf_pkg::sts_t  sts
);
	import rivf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DT   = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_P0   = 4'd4;
	localparam logic [3:0] S_P1   = 4'd5;
	localparam logic [3:0] S_P2   = 4'd6;
	localparam logic [3:0] S_P3   = 4'd7;
	localparam logic [3:0] S_SQ   = 4'd8;
	localparam logic [3:0] S_DVS  = 4'd9;
	localparam logic [3:0] S_DVSW = 4'd10;
	localparam logic [3:0] S_DVC  = 4'd11;
	localparam logic [3:0] S_DVCW = 4'd12;
	localparam logic [3:0] S_WR   = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;
	localparam logic [3:0] S_OUT  = 4'd15;

	logic [3:0] state_q, state_d;
	logic [1:0] ch_q, ch_d;
	logic [1:0] status_q, status_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;

	always_comb begin
		state_d  = state_q;
		ch_d     = ch_q;
		status_d = status_q;
		cmd      = '0;
		cmd.ch   = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DT;
				end
			end
			S_DT: begin
				cmd.dt  = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.reject) begin
					status_d = ST_REJECT;
					state_d  = S_OUT;
				end else if (sts.first) begin
					cmd.first = 1'b1;
					status_d  = ST_FIRST;
					state_d   = S_OUT;
				end else begin
					cmd.grow = 1'b1;
					status_d = ST_FUSED;
					ch_d     = 2'd0;
					state_d  = S_P0;
				end
			end
			S_P0: begin
				cmd.p0  = 1'b1;
				state_d = S_P1;
			end
			S_P1: begin
				cmd.p1  = 1'b1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.p2  = 1'b1;
				state_d = S_P3;
			end
			S_P3: begin
				cmd.p3  = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_done) begin
					state_d = S_DVS;
				end
			end
			S_DVS: begin
				cmd.dv_sig_start = 1'b1;
				state_d          = S_DVSW;
			end
			S_DVSW: begin
				cmd.dv_step = 1'b1;
				if (sts.dv_done) begin
					state_d = S_DVC;
				end
			end
			S_DVC: begin
				cmd.dv_col_start = 1'b1;
				state_d          = S_DVCW;
			end
			S_DVCW: begin
				cmd.dv_step = 1'b1;
				if (sts.dv_done) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.wr_ch = 1'b1;
				if (ch_q == 2'd2) begin
					state_d = S_FIN;
				end else begin
					ch_d    = ch_q + 2'd1;
					state_d = S_P0;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ch_q     <= 2'd0;
			status_q <= ST_REJECT;
		end else begin
			state_q  <= state_d;
			ch_q     <= ch_d;
			status_q <= status_d;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while a result is pending");
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("accepted request did not start processing");
	a_status_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)))
		else $error("stalled result changed");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("illegal status code");
`endif

endmodule

FILE: rtl/core/rivf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rivf_datapath
// Point state, gate and noise arithmetic, and a shared bit-serial
// square root and divider for the per-channel update.
// ----------------------------------------------------------------------------
module rivf_datapath #(
	parameter int COLOR_FRAC_BITS = rivf_pkg::COLOR_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rivf_pkg::cmd_t  cmd,
	output rivf_pkg::sts_t  sts,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [23:0]     cfg_data,
	input  logic            clear_point,
	input  logic [15:0]     obs_red,
	input  logic [15:0]     obs_green,
	input  logic [15:0]     obs_blue,
	input  logic [15:0]     obs_sigma_red,
	input  logic [15:0]     obs_sigma_green,
	input  logic [15:0]     obs_sigma_blue,
	input  logic [19:0]     view_distance,
	input  logic [31:0]     obs_time,
	output logic [15:0]     fused_red,
	output logic [15:0]     fused_green,
	output logic [15:0]     fused_blue,
	output logic [15:0]     sigma_red_out,
	output logic [15:0]     sigma_green_out,
	output logic [15:0]     sigma_blue_out,
	output logic [15:0]     observation_count,
	output logic [19:0]     best_distance
);
	import rivf_pkg::*;

	localparam int          GROW_SH   = 24 - COLOR_FRAC_BITS;
	localparam logic [56:0] GROW_HALF = 57'(1) << (23 - COLOR_FRAC_BITS);
	localparam logic [16:0] RND_HALF  = 17'(1) << (COLOR_FRAC_BITS - 1);

	logic [23:0] noise_q;
	logic [9:0]  ratio_q;

	logic [15:0] color_q [3];
	logic [15:0] sigma_q [3];
	logic [15:0] count_q;
	logic [19:0] closest_q;
	logic [31:0] prev_q;

	logic [15:0] x_in_q [3];
	logic [15:0] o_in_q [3];
	logic [19:0] dist_in_q;
	logic [31:0] time_in_q;

	logic [31:0] dt_q;
	logic [29:0] gp_q;
	logic [55:0] np_q;
	logic [56:0] grow_q;
	logic [15:0] s_q, o_q, c_q, x_q;
	logic [31:0] s2_q, o2_q, so_q;
	logic [32:0] d_q;
	logic [47:0] t1_q, t2_q;
	logic [49:0] ncol_q;
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [49:0] dv_num_q;
	logic [32:0] dv_rem_q, dv_div_q;
	logic [15:0] sig_q;
	logic [5:0]  cnt_q;

	logic [15:0] rnd_col [3];
	logic [16:0] rnd_tmp [3];
	logic [57:0] s_sum;
	logic [15:0] s_sat;
	logic [63:0] sq_try;
	logic [33:0] dv_r;
	logic        dv_ge;
	logic [49:0] sig_num;
	logic [15:0] q_sat;
	logic [15:0] x_sel [3];
	logic [15:0] o_sel [3];

	assign x_sel[0] = obs_red;
	assign x_sel[1] = obs_green;
	assign x_sel[2] = obs_blue;
	assign o_sel[0] = obs_sigma_red;
	assign o_sel[1] = obs_sigma_green;
	assign o_sel[2] = obs_sigma_blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_tmp[i] = ({1'b0, x_in_q[i]} + RND_HALF) >> COLOR_FRAC_BITS;
			rnd_tmp[i] = rnd_tmp[i] << COLOR_FRAC_BITS;
			rnd_col[i] = rnd_tmp[i][16] ? 16'hFFFF : rnd_tmp[i][15:0];
		end
	end

	// Grown sigma saturates before it enters the update.
	assign s_sum   = 58'(sigma_q[cmd.ch]) + 58'(grow_q);
	assign s_sat   = (|s_sum[57:16]) ? 16'hFFFF : s_sum[15:0];
	assign sq_try  = sq_res_q + sq_bit_q;
	assign dv_r    = {dv_rem_q, dv_num_q[49]};
	assign dv_ge   = (dv_r >= {1'b0, dv_div_q});
	assign sig_num = 50'({so_q, 15'b0}) + 50'(sq_res_q[63:1]);
	assign q_sat   = (|dv_num_q[49:16]) ? 16'hFFFF : dv_num_q[15:0];

	assign sts.reject  = (closest_q != 20'd0) && (30'({dist_in_q, 8'b0}) > gp_q);
	assign sts.first   = (count_q == 16'd0);
	assign sts.sq_done = (cnt_q == 6'(SQ_STEPS - 1));
	assign sts.dv_done = (cnt_q == 6'(DV_STEPS - 1));

	assign fused_red         = color_q[0];
	assign fused_green       = color_q[1];
	assign fused_blue        = color_q[2];
	assign sigma_red_out     = sigma_q[0];
	assign sigma_green_out   = sigma_q[1];
	assign sigma_blue_out    = sigma_q[2];
	assign observation_count = count_q;
	assign best_distance     = closest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q   <= NOISE_RESET;
			ratio_q   <= RATIO_RESET;
			count_q   <= 16'd0;
			closest_q <= 20'd0;
			prev_q    <= 32'd0;
			cnt_q     <= 6'd0;
			for (int i = 0; i < 3; i++) begin
				color_q[i] <= 16'd0;
				sigma_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NOISE: noise_q <= cfg_data;
					CFG_RATIO: ratio_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (cmd.capture && clear_point) begin
				count_q   <= 16'd0;
				closest_q <= 20'd0;
				prev_q    <= 32'd0;
				for (int i = 0; i < 3; i++) begin
					color_q[i] <= 16'd0;
					sigma_q[i] <= 16'd0;
				end
			end
			if (cmd.first) begin
				for (int i = 0; i < 3; i++) begin
					color_q[i] <= rnd_col[i];
					sigma_q[i] <= o_in_q[i];
				end
				closest_q <= dist_in_q;
				prev_q    <= time_in_q;
				count_q   <= 16'd1;
			end
			if (cmd.wr_ch) begin
				if (d_q == 33'd0) begin
					sigma_q[cmd.ch] <= 16'd0;
				end else begin
					sigma_q[cmd.ch] <= sig_q;
					color_q[cmd.ch] <= q_sat;
				end
			end
			if (cmd.finish) begin
				if (dist_in_q < closest_q) begin
					closest_q <= dist_in_q;
				end
				prev_q <= time_in_q;
				if (count_q != 16'hFFFF) begin
					count_q <= count_q + 16'd1;
				end
			end
			if (cmd.p3 || cmd.dv_sig_start || cmd.dv_col_start) begin
				cnt_q <= 6'd0;
			end else if (cmd.sq_step || cmd.dv_step) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 3; i++) begin
				x_in_q[i] <= x_sel[i];
				o_in_q[i] <= o_sel[i];
			end
			dist_in_q <= view_distance;
			time_in_q <= obs_time;
		end
		if (cmd.dt) begin
			dt_q <= (time_in_q >= prev_q) ? (time_in_q - prev_q) : 32'd0;
		end
		if (cmd.mul) begin
			gp_q <= 30'(closest_q) * 30'(ratio_q);
			np_q <= 56'(noise_q) * 56'(dt_q);
		end
		if (cmd.grow) begin
			grow_q <= (57'(np_q) + GROW_HALF) >> GROW_SH;
		end
		if (cmd.p0) begin
			s_q <= s_sat;
			o_q <= o_in_q[cmd.ch];
			c_q <= color_q[cmd.ch];
			x_q <= x_in_q[cmd.ch];
		end
		if (cmd.p1) begin
			s2_q <= 32'(s_q) * 32'(s_q);
			o2_q <= 32'(o_q) * 32'(o_q);
			so_q <= 32'(s_q) * 32'(o_q);
		end
		if (cmd.p2) begin
			d_q  <= 33'(s2_q) + 33'(o2_q);
			t1_q <= 48'(c_q) * 48'(o2_q);
			t2_q <= 48'(x_q) * 48'(s2_q);
		end
		if (cmd.p3) begin
			ncol_q   <= 50'(t1_q) + 50'(t2_q) + 50'(d_q[32:1]);
			sq_v_q   <= {1'b0, d_q, 30'b0};
			sq_res_q <= 64'd0;
			sq_bit_q <= 64'd1 << 62;
		end
		// One result bit of the square root per cycle.
		if (cmd.sq_step) begin
			if (sq_v_q >= sq_try) begin
				sq_v_q   <= sq_v_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.dv_sig_start) begin
			dv_num_q <= sig_num;
			dv_rem_q <= 33'd0;
			dv_div_q <= 33'(sq_res_q[31:0]);
		end
		if (cmd.dv_col_start) begin
			sig_q    <= q_sat;
			dv_num_q <= ncol_q;
			dv_rem_q <= 33'd0;
			dv_div_q <= d_q;
		end
		// Restoring division: quotient bits shift in where numerator bits leave.
		if (cmd.dv_step) begin
			dv_num_q <= {dv_num_q[48:0], dv_ge};
			dv_rem_q <= dv_ge ? 33'(dv_r - {1'b0, dv_div_q}) : dv_r[32:0];
		end
	end

endmodule

FILE: rtl/core/rgb_inverse_variance_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_inverse_variance_fusion
// Inverse-variance fusion of color observations of one map point.
// ----------------------------------------------------------------------------
// Sequence: a gated or first request goes through S_DT, S_MUL and S_DEC to
// S_OUT; a fused request adds, per channel, S_P0 to S_P3, 32 square root
// steps and two 50-step divisions on one shared bit-serial unit.
// One request is in work at a time. The next request can be taken once the
// controller is back in S_IDLE, which it reaches from S_OUT when the result
// is not stalled. Reset clears the point state and loads the register defaults.
module rgb_inverse_variance_fusion #(
	parameter int COLOR_FRAC_BITS = rivf_pkg::COLOR_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        clear_point,
	input  logic [15:0] obs_red,
	input  logic [15:0] obs_green,
	input  logic [15:0] obs_blue,
	input  logic [15:0] obs_sigma_red,
	input  logic [15:0] obs_sigma_green,
	input  logic [15:0] obs_sigma_blue,
	input  logic [19:0] view_distance,
	input  logic [31:0] obs_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] fused_red,
	output logic [15:0] fused_green,
	output logic [15:0] fused_blue,
	output logic [15:0] sigma_red_out,
	output logic [15:0] sigma_green_out,
	output logic [15:0] sigma_blue_out,
	output logic [15:0] observation_count,
	output logic [19:0] best_distance
);
	import rivf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rivf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.sts       (sts)
	);

	rivf_datapath #(
		.COLOR_FRAC_BITS (COLOR_FRAC_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.clear_point       (clear_point),
		.obs_red           (obs_red),
		.obs_green         (obs_green),
		.obs_blue          (obs_blue),
		.obs_sigma_red     (obs_sigma_red),
		.obs_sigma_green   (obs_sigma_green),
		.obs_sigma_blue    (obs_sigma_blue),
		.view_distance     (view_distance),
		.obs_time          (obs_time),
		.fused_red         (fused_red),
		.fused_green       (fused_green),
		.fused_blue        (fused_blue),
		.sigma_red_out     (sigma_red_out),
		.sigma_green_out   (sigma_green_out),
		.sigma_blue_out    (sigma_blue_out),
		.observation_count (observation_count),
		.best_distance     (best_distance)
	);

endmodule

FILE: bench/rgb_inverse_variance_fusion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_inverse_variance_fusion_tb
// Drives color observations of one map point into the fusion block and checks
// every result against a bit-exact fusion predictor kept in the bench. Both
// registers are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module rgb_inverse_variance_fusion_tb;
	import rivf_pkg::*;

	typedef struct packed {
		logic        clr;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] sig_red;
		logic [15:0] sig_green;
		logic [15:0] sig_blue;
		logic [19:0] vdist;
		logic [31:0] tstamp;
	} obs_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] sig_red;
		logic [15:0] sig_green;
		logic [15:0] sig_blue;
		logic [15:0] count;
		logic [19:0] best;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_NOISE;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        clear_point = 1'b0;
	logic [15:0] obs_red = '0, obs_green = '0, obs_blue = '0;
	logic [15:0] obs_sigma_red = 16'd1, obs_sigma_green = 16'd1, obs_sigma_blue = 16'd1;
	logic [19:0] view_distance = '0;
	logic [31:0] obs_time = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] fused_red, fused_green, fused_blue;
	logic [15:0] sigma_red_out, sigma_green_out, sigma_blue_out;
	logic [15:0] observation_count;
	logic [19:0] best_distance;

	rgb_inverse_variance_fusion dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state of the map point and the register copies.
	logic [23:0] pr_noise;
	logic [9:0]  pr_ratio;
	logic [15:0] pr_color [3];
	logic [15:0] pr_sigma [3];
	logic [15:0] pr_count;
	logic [19:0] pr_best;
	logic [31:0] pr_time;

	obs_t   pending_obs[$];
	point_t expected_points[$];
	int     errors = 0;
	int     long_hold = 0;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic fuse_one(int ch, logic [63:0] x, logic [63:0] o, logic [63:0] grow);
		logic [63:0] s, c, s2, o2, d, root, sig, col;
		s = 64'(pr_sigma[ch]) + grow;
		if (s > 64'hFFFF) s = 64'hFFFF;
		c = 64'(pr_color[ch]);
		s2 = s * s;
		o2 = o * o;
		d = s2 + o2;
		if (d == 0) begin
			pr_sigma[ch] = 16'd0;
			return;
		end
		root = int_sqrt(d << 30);
		sig = (((s * o) << 15) + (root >> 1)) / root;
		col = (c * o2 + x * s2 + (d >> 1)) / d;
		pr_sigma[ch] = sig > 64'hFFFF ? 16'hFFFF : sig[15:0];
		pr_color[ch] = col > 64'hFFFF ? 16'hFFFF : col[15:0];
	endtask

	task automatic predict_fusion(obs_t ob);
		logic [63:0] xs [3];
		logic [63:0] os [3];
		logic [63:0] dt, grow, rw;
		logic [1:0]  st;
		point_t      pt;
		xs[0] = 64'(ob.red); xs[1] = 64'(ob.green); xs[2] = 64'(ob.blue);
		os[0] = 64'(ob.sig_red); os[1] = 64'(ob.sig_green); os[2] = 64'(ob.sig_blue);
		if (ob.clr) begin
			for (int i = 0; i < 3; i++) begin
				pr_color[i] = 16'd0;
				pr_sigma[i] = 16'd0;
			end
			pr_count = 16'd0; pr_best = 20'd0; pr_time = 32'd0;
		end
		if (pr_best != 0 && ({44'd0, ob.vdist} << 8) > 64'(pr_best) * 64'(pr_ratio)) begin
			st = ST_REJECT;
		end else if (pr_count == 0) begin
			for (int i = 0; i < 3; i++) begin
				rw = ((xs[i] + 64'd128) >> 8) << 8;
				pr_color[i] = rw > 64'hFFFF ? 16'hFFFF : rw[15:0];
				pr_sigma[i] = os[i][15:0];
			end
			pr_best = ob.vdist;
			pr_time = ob.tstamp;
			pr_count = 16'd1;
			st = ST_FIRST;
		end else begin
			dt = ob.tstamp >= pr_time ? 64'(ob.tstamp - pr_time) : 64'd0;
			grow = (64'(pr_noise) * dt + (64'd1 << 15)) >> 16;
			for (int i = 0; i < 3; i++) fuse_one(i, xs[i], os[i], grow);
			if (ob.vdist < pr_best) pr_best = ob.vdist;
			pr_time = ob.tstamp;
			if (pr_count != 16'hFFFF) pr_count++;
			st = ST_FUSED;
		end
		pt = '{st, pr_color[0], pr_color[1], pr_color[2],
			pr_sigma[0], pr_sigma[1], pr_sigma[2], pr_count, pr_best};
		expected_points.push_back(pt);
	endtask

	// Driver: bursts with random gaps; the payload holds while stalled.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_fusion('{clear_point, obs_red, obs_green, obs_blue, obs_sigma_red,
					obs_sigma_green, obs_sigma_blue, view_distance, obs_time});
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_obs.size() > 0) begin
					obs_t ob;
					ob = pending_obs.pop_front();
					{clear_point, obs_red, obs_green, obs_blue, obs_sigma_red,
						obs_sigma_green, obs_sigma_blue, view_distance, obs_time} <= ob;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(900, 0);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off.
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				out_stall <= 1'b1;
			end else if (stall_phase[11]) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(4, 0) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			point_t got, exp_pt;
			got = '{status, fused_red, fused_green, fused_blue, sigma_red_out,
				sigma_green_out, sigma_blue_out, observation_count, best_distance};
			if (expected_points.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (got.st !== exp_pt.st) begin
					$error("status expected %0d got %0d", exp_pt.st, got.st); errors++;
				end
				if (got.red !== exp_pt.red) begin
					$error("fused_red expected %0d got %0d", exp_pt.red, got.red); errors++;
				end
				if (got.green !== exp_pt.green) begin
					$error("fused_green expected %0d got %0d", exp_pt.green, got.green);
					errors++;
				end
				if (got.blue !== exp_pt.blue) begin
					$error("fused_blue expected %0d got %0d", exp_pt.blue, got.blue); errors++;
				end
				if (got.sig_red !== exp_pt.sig_red) begin
					$error("sigma_red_out expected %0d got %0d", exp_pt.sig_red, got.sig_red);
					errors++;
				end
				if (got.sig_green !== exp_pt.sig_green) begin
					$error("sigma_green_out expected %0d got %0d", exp_pt.sig_green,
						got.sig_green);
					errors++;
				end
				if (got.sig_blue !== exp_pt.sig_blue) begin
					$error("sigma_blue_out expected %0d got %0d", exp_pt.sig_blue,
						got.sig_blue);
					errors++;
				end
				if (got.count !== exp_pt.count) begin
					$error("observation_count expected %0d got %0d", exp_pt.count, got.count);
					errors++;
				end
				if (got.best !== exp_pt.best) begin
					$error("best_distance expected %0d got %0d", exp_pt.best, got.best);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_obs.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_NOISE) pr_noise = val;
		else pr_ratio = val[9:0];
	endtask

	function automatic obs_t random_obs(logic clr, logic [31:0] t_base);
		obs_t ob;
		ob.clr = clr;
		ob.red = 16'($urandom); ob.green = 16'($urandom); ob.blue = 16'($urandom);
		// Mostly small sigmas so that fusion moves the colors, some full range.
		ob.sig_red = 16'(($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(4000, 0));
		ob.sig_green = 16'(($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(4000, 0));
		ob.sig_blue = 16'(($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(4000, 0));
		if (ob.sig_red == 0) ob.sig_red = 16'd1;
		if (ob.sig_green == 0) ob.sig_green = 16'd1;
		if (ob.sig_blue == 0) ob.sig_blue = 16'd1;
		ob.vdist = 20'(($urandom_range(4, 0) == 0) ? $urandom : $urandom_range(6000, 800));
		ob.tstamp = ($urandom_range(9, 0) == 0) ? $urandom : t_base + $urandom_range(5000, 0);
		return ob;
	endfunction

	initial begin
		logic [31:0] t;
		obs_t ob;
		pr_noise = NOISE_RESET;
		pr_ratio = RATIO_RESET;
		for (int i = 0; i < 3; i++) begin
			pr_color[i] = 16'd0;
			pr_sigma[i] = 16'd0;
		end
		pr_count = 16'd0; pr_best = 20'd0; pr_time = 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, rounding saturation, gate, backward time.
		pending_obs.push_back('{1'b0, 16'hFFFF, 16'h0080, 16'h007F, 16'hFFFF, 16'd1,
			16'd256, 20'd1000, 32'd100});
		pending_obs.push_back('{1'b0, 16'h0, 16'hFFFF, 16'h8000, 16'd1, 16'hFFFF,
			16'd256, 20'd1200, 32'd50});
		pending_obs.push_back('{1'b0, 16'h1234, 16'h0, 16'hFFFF, 16'd300, 16'd300,
			16'd300, 20'd1201, 32'd2000});
		pending_obs.push_back('{1'b0, 16'h5555, 16'hAAAA, 16'h0, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 20'd500, 32'hFFFF_FFFF});
		pending_obs.push_back('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 20'hFFFFF, 32'd0});
		pending_obs.push_back('{1'b0, 16'h0, 16'h0, 16'h0, 16'd1, 16'd1, 16'd1,
			20'd0, 32'hFFFF_FFFF});
		pending_obs.push_back('{1'b1, 16'h0, 16'h0, 16'h0, 16'd5, 16'd5, 16'd5,
			20'd0, 32'd0});
		pending_obs.push_back('{1'b0, 16'h7F80, 16'h7F7F, 16'h0180, 16'd5, 16'd5, 16'd5,
			20'hFFFFF, 32'd10});
		wait_drained();

		// Extreme noise makes the grown sigma saturate; a gate ratio of one (256).
		write_reg(CFG_NOISE, 24'hFFFFFF);
		write_reg(CFG_RATIO, 24'd256);
		pending_obs.push_back('{1'b1, 16'h1000, 16'h2000, 16'h3000, 16'd100, 16'd200,
			16'd300, 20'd2000, 32'd0});
		pending_obs.push_back('{1'b0, 16'h4000, 16'h5000, 16'h6000, 16'd100, 16'd200,
			16'd300, 20'd2000, 32'd70000});
		pending_obs.push_back('{1'b0, 16'h4000, 16'h5000, 16'h6000, 16'd100, 16'd200,
			16'd300, 20'd2001, 32'd70001});
		wait_drained();

		// Random phases through several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_NOISE, 24'd0);
					write_reg(CFG_RATIO, 24'd1023);
				end
				1: begin
					write_reg(CFG_NOISE, NOISE_RESET);
					write_reg(CFG_RATIO, 24'(RATIO_RESET));
				end
				2: begin
					write_reg(CFG_NOISE, 24'($urandom));
					write_reg(CFG_RATIO, 24'($urandom_range(1023, 256)));
				end
				3: begin
					write_reg(CFG_NOISE, 24'($urandom_range(200000, 0)));
					write_reg(CFG_RATIO, 24'd400);
				end
				default: begin
					write_reg(CFG_NOISE, 24'd5000);
					write_reg(CFG_RATIO, 24'd300);
				end
			endcase
			t = $urandom;
			for (int n = 0; n < 105; n++) begin
				ob = random_obs($urandom_range(15, 0) == 0, t);
				t = ob.tstamp;
				pending_obs.push_back(ob);
			end
			if (ph == 2) begin
				// Hold the receiver off while the sender keeps offering.
				@(posedge clk);
				long_hold <= 3000;
			end
			wait_drained();
		end
		repeat (500) @(posedge clk);
		if (errors == 0) begin
			$display("PASS rgb_inverse_variance_fusion");
		end else begin
			$display("FAIL rgb_inverse_variance_fusion");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL rgb_inverse_variance_fusion");
		$finish;
	end

endmodule

FILE: rgb_inverse_variance_fusion.f
rtl/core/rivf_pkg.sv
rtl/core/rivf_ctrl.sv
rtl/core/rivf_datapath.sv
rtl/core/rgb_inverse_variance_fusion.sv
bench/rgb_inverse_variance_fusion_tb.sv
